// ===== rtl/hrp_pkg.sv =====
package hrp_pkg;

	// Field widths of the byte and result words
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned EVENT_W      = 4;
	localparam int unsigned ERROR_W      = 2;
	localparam int unsigned POS_OUT_W    = 16;
	localparam int unsigned METHOD_W     = 2;
	localparam int unsigned MINOR_W      = 4;
	localparam int unsigned METH_LEN_W   = 3;

	// Default width of the byte offset counter
	localparam int unsigned POSITION_BITS_DEF = 16;

	// Characters the parser looks for
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_UPA   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPZ   = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
	localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
	localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
	localparam logic [BYTE_W-1:0] CH_DIG0  = 8'd48;
	localparam logic [BYTE_W-1:0] CH_DIG9  = 8'd57;

	// Saturation point of the method length count
	localparam logic [METH_LEN_W-1:0] METH_LEN_MAX = '1;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE         = 4'd0,
		EV_METHOD_END   = 4'd1,
		EV_URI_START    = 4'd2,
		EV_URI_END      = 4'd3,
		EV_VERSION_DONE = 4'd4,
		EV_LINE_DONE    = 4'd5,
		EV_KEY_START    = 4'd6,
		EV_KEY_END      = 4'd7,
		EV_VALUE_START  = 4'd8,
		EV_VALUE_END    = 4'd9,
		EV_HEADER_DONE  = 4'd10,
		EV_HEADERS_DONE = 4'd11
	} event_t;

	typedef enum logic [ERROR_W-1:0] {
		ERR_NONE    = 2'd0,
		ERR_METHOD  = 2'd1,
		ERR_REQUEST = 2'd2,
		ERR_HEADER  = 2'd3
	} err_t;

	typedef enum logic [METHOD_W-1:0] {
		METH_UNKNOWN = 2'd0,
		METH_GET     = 2'd1,
		METH_POST    = 2'd2,
		METH_HEAD    = 2'd3
	} meth_t;

	typedef enum logic [1:0] {
		FL_OTHER = 2'd0,
		FL_G     = 2'd1,
		FL_P     = 2'd2,
		FL_H     = 2'd3
	} letter_t;

	// One result word
	typedef struct packed {
		event_t               ev;
		err_t                 err;
		logic [POS_OUT_W-1:0] pos;
		meth_t                meth;
		logic                 major;
		logic [MINOR_W-1:0]   minor;
	} res_t;

	function automatic logic is_method_char(input logic [BYTE_W-1:0] c);
		return ((c >= CH_UPA) && (c <= CH_UPZ)) || (c == CH_UNDER);
	endfunction

	function automatic letter_t first_letter(input logic [BYTE_W-1:0] c);
		letter_t l;
		priority if (c == CH_G) l = FL_G;
		else if (c == CH_P) l = FL_P;
		else if (c == CH_H) l = FL_H;
		else l = FL_OTHER;
		return l;
	endfunction

	// Classify the method from its length and first letter
	function automatic meth_t method_class(input logic [METH_LEN_W-1:0] len,
			input letter_t fl);
		meth_t m;
		priority if (len == 3'd3 && fl == FL_G) m = METH_GET;
		else if (len == 3'd4 && fl == FL_P) m = METH_POST;
		else if (len == 3'd4 && fl == FL_H) m = METH_HEAD;
		else m = METH_UNKNOWN;
		return m;
	endfunction

endpackage

// ===== rtl/hrp_in_if.sv =====
interface hrp_in_if;
	import hrp_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);

endinterface

// ===== rtl/hrp_out_if.sv =====
interface hrp_out_if;
	import hrp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [EVENT_W-1:0]   event_res;
	logic [ERROR_W-1:0]   error_code;
	logic [POS_OUT_W-1:0] byte_position;
	logic [METHOD_W-1:0]  method_class;
	logic                 version_major;
	logic [MINOR_W-1:0]   version_minor;

	modport source (output valid, output event_res, output error_code,
		output byte_position, output method_class, output version_major,
		output version_minor, input ready);
	modport sink (input valid, input event_res, input error_code,
		input byte_position, input method_class, input version_major,
		input version_minor, output ready);

endinterface

// ===== rtl/hrp_core.sv =====
module hrp_core #(
	parameter int unsigned POSITION_BITS = hrp_pkg::POSITION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       kind,
	input  logic [hrp_pkg::BYTE_W-1:0] data_byte,
	output hrp_pkg::res_t              result
);
	import hrp_pkg::*;

	typedef enum logic [23:0] {
		PH_START     = 24'h000001,
		PH_METHOD    = 24'h000002,
		PH_SP_URI    = 24'h000004,
		PH_URI       = 24'h000008,
		PH_HTTP      = 24'h000010,
		PH_H         = 24'h000020,
		PH_HT        = 24'h000040,
		PH_HTT       = 24'h000080,
		PH_HTTPS     = 24'h000100,
		PH_SLASH     = 24'h000200,
		PH_MAJOR     = 24'h000400,
		PH_POINT     = 24'h000800,
		PH_MINOR     = 24'h001000,
		PH_LAST_CR   = 24'h002000,
		PH_HDR_START = 24'h004000,
		PH_KEY       = 24'h008000,
		PH_SP_BEFORE = 24'h010000,
		PH_SP_AFTER  = 24'h020000,
		PH_VALUE     = 24'h040000,
		PH_VAL_CR    = 24'h080000,
		PH_CRLF      = 24'h100000,
		PH_CRLFCR    = 24'h200000,
		PH_DONE      = 24'h400000,
		PH_ERROR     = 24'h800000
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [POSITION_BITS-1:0] cnt_q, cnt_d;
	logic [METH_LEN_W-1:0]    len_q, len_d;
	letter_t                  fl_q, fl_d;
	meth_t                    meth_q, meth_d;
	logic                     major_q, major_d;
	logic [MINOR_W-1:0]       minor_q, minor_d;
	err_t                     err_q, err_d;
	event_t                   ev;
	logic [POS_OUT_W-1:0]     pos_now;
	logic                     is_blank;
	logic [BYTE_W-1:0]        c;

	assign c        = data_byte;
	assign is_blank = (c == CH_CR) || (c == CH_LF);

	// Show the offset, clamped to the output width
	if (POSITION_BITS > POS_OUT_W) begin : g_pos_sat
		assign pos_now = (|cnt_q[POSITION_BITS-1:POS_OUT_W]) ? '1
			: cnt_q[POS_OUT_W-1:0];
	end else begin : g_pos_ext
		assign pos_now = POS_OUT_W'(cnt_q);
	end

	// Parse one byte
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		fl_d    = fl_q;
		meth_d  = meth_q;
		major_d = major_q;
		minor_d = minor_q;
		err_d   = err_q;
		ev      = EV_NONE;

		if (kind) begin
			phase_d = PH_START;
			cnt_d   = '0;
			len_d   = '0;
			fl_d    = FL_OTHER;
			meth_d  = METH_UNKNOWN;
			major_d = 1'b0;
			minor_d = '0;
			err_d   = ERR_NONE;
		end else begin
			if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
			unique case (phase_q)
				PH_START: begin
					if (!is_blank) begin
						if (!is_method_char(c)) begin
							err_d = ERR_METHOD; phase_d = PH_ERROR;
						end else begin
							len_d   = 3'd1;
							fl_d    = first_letter(c);
							phase_d = PH_METHOD;
						end
					end
				end
				PH_METHOD: begin
					if (c == CH_SP) begin
						meth_d  = method_class(len_q, fl_q);
						ev      = EV_METHOD_END;
						phase_d = PH_SP_URI;
					end else if (!is_blank && !is_method_char(c)) begin
						err_d = ERR_METHOD; phase_d = PH_ERROR;
					end else if (len_q != METH_LEN_MAX) begin
						len_d = len_q + 1'b1;
					end
				end
				PH_SP_URI: begin
					if (c == CH_SLASH) begin
						ev = EV_URI_START; phase_d = PH_URI;
					end else if (c != CH_SP) begin
						err_d = ERR_REQUEST; phase_d = PH_ERROR;
					end
				end
				PH_URI: begin
					if (c == CH_SP) begin
						ev = EV_URI_END; phase_d = PH_HTTP;
					end
				end
				PH_HTTP: begin
					if (c == CH_H) phase_d = PH_H;
					else if (c != CH_SP) begin
						err_d = ERR_REQUEST; phase_d = PH_ERROR;
					end
				end
				PH_H: begin
					if (c == CH_T) phase_d = PH_HT;
					else begin err_d = ERR_METHOD; phase_d = PH_ERROR; end
				end
				PH_HT: begin
					if (c == CH_T) phase_d = PH_HTT;
					else begin err_d = ERR_METHOD; phase_d = PH_ERROR; end
				end
				PH_HTT: begin
					if (c == CH_P) phase_d = PH_HTTPS;
					else begin err_d = ERR_METHOD; phase_d = PH_ERROR; end
				end
				PH_HTTPS: begin
					if (c == CH_SLASH) phase_d = PH_SLASH;
					else begin err_d = ERR_METHOD; phase_d = PH_ERROR; end
				end
				PH_SLASH: begin
					if (c == CH_ONE) begin
						major_d = 1'b1; phase_d = PH_MAJOR;
					end else begin
						err_d = ERR_METHOD; phase_d = PH_ERROR;
					end
				end
				PH_MAJOR: begin
					if (c == CH_DOT) phase_d = PH_POINT;
					else begin err_d = ERR_METHOD; phase_d = PH_ERROR; end
				end
				PH_POINT: begin
					if (c < CH_DIG0 || c > CH_DIG9) begin
						err_d = ERR_METHOD; phase_d = PH_ERROR;
					end else begin
						minor_d = MINOR_W'(c - CH_DIG0);
						ev      = EV_VERSION_DONE;
						phase_d = PH_MINOR;
					end
				end
				PH_MINOR: begin
					if (c == CH_CR) phase_d = PH_LAST_CR;
				end
				PH_LAST_CR: begin
					if (c == CH_LF) begin
						ev = EV_LINE_DONE; phase_d = PH_HDR_START;
					end else begin
						err_d = ERR_REQUEST; phase_d = PH_ERROR;
					end
				end
				PH_HDR_START: begin
					if (!is_blank) begin
						ev = EV_KEY_START; phase_d = PH_KEY;
					end
				end
				PH_KEY: begin
					if (c == CH_SP) begin
						ev = EV_KEY_END; phase_d = PH_SP_BEFORE;
					end else if (c == CH_COLON) begin
						ev = EV_KEY_END; phase_d = PH_SP_AFTER;
					end
				end
				PH_SP_BEFORE: begin
					if (c == CH_COLON) phase_d = PH_SP_AFTER;
					else if (c != CH_SP) begin
						err_d = ERR_HEADER; phase_d = PH_ERROR;
					end
				end
				PH_SP_AFTER: begin
					if (c != CH_SP) begin
						ev = EV_VALUE_START; phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					// A bare LF closes the header as well
					if (c == CH_CR) begin
						ev = EV_VALUE_END; phase_d = PH_VAL_CR;
					end else if (c == CH_LF) begin
						ev = EV_HEADER_DONE; phase_d = PH_CRLF;
					end
				end
				PH_VAL_CR: begin
					if (c == CH_LF) begin
						ev = EV_HEADER_DONE; phase_d = PH_CRLF;
					end else begin
						err_d = ERR_HEADER; phase_d = PH_ERROR;
					end
				end
				PH_CRLF: begin
					if (c == CH_CR) phase_d = PH_CRLFCR;
					else begin
						ev = EV_KEY_START; phase_d = PH_KEY;
					end
				end
				PH_CRLFCR: begin
					if (c == CH_LF) begin
						ev = EV_HEADERS_DONE; phase_d = PH_DONE;
					end else begin
						err_d = ERR_HEADER; phase_d = PH_ERROR;
					end
				end
				PH_DONE, PH_ERROR: begin
					// drop the byte
				end
				default: begin
				end
			endcase
		end
	end

	// Build the result word from the updated state
	always_comb begin
		result.ev    = ev;
		result.err   = err_d;
		result.pos   = kind ? '0 : pos_now;
		result.meth  = meth_d;
		result.major = major_d;
		result.minor = minor_d;
	end

	// Advance parser state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			len_q   <= '0;
			fl_q    <= FL_OTHER;
			meth_q  <= METH_UNKNOWN;
			major_q <= 1'b0;
			minor_q <= '0;
			err_q   <= ERR_NONE;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			fl_q    <= fl_d;
			meth_q  <= meth_d;
			major_q <= major_d;
			minor_q <= minor_d;
			err_q   <= err_d;
		end
	end

endmodule

// ===== rtl/http_request_head_parser_top.sv =====
// HTTP request head parser.
// req carries one word per handshake: kind = 0 with the next request byte in
// data_byte, or kind = 1 to start a new request (parser cleared, byte unused).
// res returns exactly one word per accepted req word: the boundary event the
// byte caused, its offset since request start (clamped to 16 bits), the method
// class, the HTTP version and a sticky error code.
// The result of an accepted word is registered in the output stage, or in the skid register while a result waits.
// Throughput: one word per cycle while req.ready is high; the whole parse step is one pass through the
// state logic between the parser registers and the result register.
// Stall: a two-entry output stage (result register plus skid register) lets
// one more word in while a result waits; req.ready drops only when both hold
// words, and comes back the cycle after res takes one.
// Reset: arst_n clears the parser to the start of a request line and empties
// the output stage; a word can be taken as soon as reset is released.
// The offset counter is POSITION_BITS wide and saturates at its maximum.
module http_request_head_parser_top #(
	parameter int unsigned POSITION_BITS = hrp_pkg::POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hrp_in_if.sink     req,
	hrp_out_if.source  res
);
	import hrp_pkg::*;

	res_t new_res;
	res_t out_q, skid_q;
	logic out_v_q, skid_v_q;
	logic step;
	logic out_free;

	assign req.ready = !skid_v_q;
	assign step      = req.valid && req.ready;
	assign out_free  = res.ready || !out_v_q;

	hrp_core #(
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.kind      (req.kind),
		.data_byte (req.data_byte),
		.result    (new_res)
	);

	// Track which output entries hold a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= step;
			end
		end else if (step) begin
			skid_v_q <= 1'b1;
		end
	end

	// Load result payloads
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) out_q <= skid_q;
			else if (step) out_q <= new_res;
		end else if (step) begin
			skid_q <= new_res;
		end
	end

	assign res.valid         = out_v_q;
	assign res.event_res     = out_q.ev;
	assign res.error_code    = out_q.err;
	assign res.byte_position = out_q.pos;
	assign res.method_class  = out_q.meth;
	assign res.version_major = out_q.major;
	assign res.version_minor = out_q.minor;

endmodule

// ===== rtl/hrp_chk.sv =====
module hrp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [hrp_pkg::EVENT_W-1:0]   event_res,
	input logic [hrp_pkg::ERROR_W-1:0]   error_code,
	input logic [hrp_pkg::POS_OUT_W-1:0] byte_position,
	input logic                          version_major
);
	import hrp_pkg::*;

	// A stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(event_res)
			&& $stable(error_code) && $stable(byte_position))
		else $error("stalled result word changed");

	// With no result pending the parser must take a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("input stalled with empty output stage");

	// Once failed, the parser reports no boundaries
	a_err_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error_code != ERR_NONE |-> event_res == EV_NONE)
		else $error("boundary event reported with error set");

	// Event codes stay in the defined range
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> event_res <= EV_HEADERS_DONE)
		else $error("undefined event code");

	// Version done implies the major digit was seen
	a_version_major: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_VERSION_DONE |-> version_major)
		else $error("version done without major digit");

endmodule

bind http_request_head_parser_top hrp_chk u_hrp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.event_res     (res.event_res),
	.error_code    (res.error_code),
	.byte_position (res.byte_position),
	.version_major (res.version_major)
);

// ===== tb/tb_http_request_head_parser_top.sv =====
`timescale 1ns / 100ps

import hrp_pkg::*;

// Mirrors the parser byte by byte and holds the result words still due.
class request_head_board;

	typedef enum int {
		ST_LINE_START, ST_METHOD, ST_URI_GAP, ST_URI, ST_PROTO_GAP, ST_H, ST_HT,
		ST_HTT, ST_HTTP, ST_SLASH, ST_MAJOR, ST_DOT, ST_MINOR, ST_LINE_CR,
		ST_HDR_START, ST_KEY, ST_KEY_SP, ST_VAL_GAP, ST_VALUE, ST_VALUE_CR,
		ST_HDR_END, ST_END_CR, ST_DONE, ST_ERROR
	} stage_t;

	stage_t                stage;
	longint unsigned       offset;
	logic [METH_LEN_W-1:0] mlen;
	letter_t               letter;
	meth_t                 meth;
	logic                  major;
	logic [MINOR_W-1:0]    minor;
	err_t                  err;
	res_t                  results_due[$];
	int unsigned           fail_count;

	function new();
		fail_count = 0;
		clear();
	endfunction

	function void clear();
		stage = ST_LINE_START;
		offset = 0;
		mlen = '0;
		letter = FL_OTHER;
		meth = METH_UNKNOWN;
		major = 1'b0;
		minor = '0;
		err = ERR_NONE;
	endfunction

	function bit upper_or_under(input logic [BYTE_W-1:0] c);
		return (c >= CH_UPA && c <= CH_UPZ) || c == CH_UNDER;
	endfunction

	function void abort(input err_t code);
		err = code;
		stage = ST_ERROR;
	endfunction

	// Advance the parse by one byte and return the boundary it marks
	function event_t parse_byte(input logic [BYTE_W-1:0] c);
		event_t ev;
		ev = EV_NONE;
		case (stage)
			ST_LINE_START: begin
				if (c != CH_CR && c != CH_LF) begin
					if (!upper_or_under(c)) begin
						abort(ERR_METHOD);
					end else begin
						mlen = METH_LEN_W'(1);
						case (c)
							CH_G: letter = FL_G;
							CH_P: letter = FL_P;
							CH_H: letter = FL_H;
							default: letter = FL_OTHER;
						endcase
						stage = ST_METHOD;
					end
				end
			end
			ST_METHOD: begin
				if (c == CH_SP) begin
					if (mlen == 3 && letter == FL_G) meth = METH_GET;
					else if (mlen == 4 && letter == FL_P) meth = METH_POST;
					else if (mlen == 4 && letter == FL_H) meth = METH_HEAD;
					else meth = METH_UNKNOWN;
					ev = EV_METHOD_END;
					stage = ST_URI_GAP;
				end else if (c != CH_CR && c != CH_LF && !upper_or_under(c)) begin
					abort(ERR_METHOD);
				end else if (mlen != METH_LEN_MAX) begin
					mlen++;
				end
			end
			ST_URI_GAP: begin
				if (c == CH_SLASH) begin
					ev = EV_URI_START;
					stage = ST_URI;
				end else if (c != CH_SP) begin
					abort(ERR_REQUEST);
				end
			end
			ST_URI: begin
				if (c == CH_SP) begin
					ev = EV_URI_END;
					stage = ST_PROTO_GAP;
				end
			end
			ST_PROTO_GAP: begin
				if (c == CH_H) stage = ST_H;
				else if (c != CH_SP) abort(ERR_REQUEST);
			end
			ST_H: begin
				if (c == CH_T) stage = ST_HT; else abort(ERR_METHOD);
			end
			ST_HT: begin
				if (c == CH_T) stage = ST_HTT; else abort(ERR_METHOD);
			end
			ST_HTT: begin
				if (c == CH_P) stage = ST_HTTP; else abort(ERR_METHOD);
			end
			ST_HTTP: begin
				if (c == CH_SLASH) stage = ST_SLASH; else abort(ERR_METHOD);
			end
			ST_SLASH: begin
				if (c == CH_ONE) begin
					major = 1'b1;
					stage = ST_MAJOR;
				end else begin
					abort(ERR_METHOD);
				end
			end
			ST_MAJOR: begin
				if (c == CH_DOT) stage = ST_DOT; else abort(ERR_METHOD);
			end
			ST_DOT: begin
				if (c < CH_DIG0 || c > CH_DIG9) begin
					abort(ERR_METHOD);
				end else begin
					minor = MINOR_W'(c - CH_DIG0);
					ev = EV_VERSION_DONE;
					stage = ST_MINOR;
				end
			end
			ST_MINOR: begin
				if (c == CH_CR) stage = ST_LINE_CR;
			end
			ST_LINE_CR: begin
				if (c == CH_LF) begin
					ev = EV_LINE_DONE;
					stage = ST_HDR_START;
				end else begin
					abort(ERR_REQUEST);
				end
			end
			ST_HDR_START: begin
				if (c != CH_CR && c != CH_LF) begin
					ev = EV_KEY_START;
					stage = ST_KEY;
				end
			end
			ST_KEY: begin
				if (c == CH_SP) begin
					ev = EV_KEY_END;
					stage = ST_KEY_SP;
				end else if (c == CH_COLON) begin
					ev = EV_KEY_END;
					stage = ST_VAL_GAP;
				end
			end
			ST_KEY_SP: begin
				if (c == CH_COLON) stage = ST_VAL_GAP;
				else if (c != CH_SP) abort(ERR_HEADER);
			end
			ST_VAL_GAP: begin
				if (c != CH_SP) begin
					ev = EV_VALUE_START;
					stage = ST_VALUE;
				end
			end
			ST_VALUE: begin
				if (c == CH_CR) begin
					ev = EV_VALUE_END;
					stage = ST_VALUE_CR;
				end else if (c == CH_LF) begin
					// bare LF closes the header directly
					ev = EV_HEADER_DONE;
					stage = ST_HDR_END;
				end
			end
			ST_VALUE_CR: begin
				if (c == CH_LF) begin
					ev = EV_HEADER_DONE;
					stage = ST_HDR_END;
				end else begin
					abort(ERR_HEADER);
				end
			end
			ST_HDR_END: begin
				if (c == CH_CR) begin
					stage = ST_END_CR;
				end else begin
					ev = EV_KEY_START;
					stage = ST_KEY;
				end
			end
			ST_END_CR: begin
				if (c == CH_LF) begin
					ev = EV_HEADERS_DONE;
					stage = ST_DONE;
				end else begin
					abort(ERR_HEADER);
				end
			end
			default: ;
		endcase
		return ev;
	endfunction

	// Note one accepted word; returns 1 unless the parser just ignores it
	function bit note_word(input logic k, input logic [BYTE_W-1:0] c);
		res_t r;
		bit   live;
		live = k || (stage != ST_DONE && stage != ST_ERROR);
		r.ev = EV_NONE;
		r.pos = '0;
		if (k) begin
			clear();
		end else begin
			r.pos = (offset > 64'hFFFF) ? 16'hFFFF : POS_OUT_W'(offset);
			r.ev = parse_byte(c);
			if (offset < (64'd1 << POSITION_BITS_DEF) - 1) offset++;
		end
		r.err = err;
		r.meth = meth;
		r.major = major;
		r.minor = minor;
		results_due.push_back(r);
		return live;
	endfunction

	function void compare(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	function void check_result(input res_t got);
		res_t want;
		if (results_due.size() == 0) begin
			fail_count++;
			$error("result word with nothing expected: event_res %0d", got.ev);
			return;
		end
		want = results_due.pop_front();
		compare("event_res", want.ev, got.ev);
		compare("error_code", want.err, got.err);
		compare("byte_position", want.pos, got.pos);
		compare("method_class", want.meth, got.meth);
		compare("version_major", want.major, got.major);
		compare("version_minor", want.minor, got.minor);
	endfunction

	function int unsigned pending();
		return results_due.size();
	endfunction

endclass

module tb_http_request_head_parser_top;

	localparam int unsigned CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;

	hrp_in_if  req();
	hrp_out_if res();

	http_request_head_parser_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	request_head_board board = new();

	int unsigned send_gap_pct = 28;
	int unsigned stall_pct = 76;
	int unsigned live_count = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Take result words and stall at random
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
				board.check_result(res_t'({res.event_res, res.error_code,
					res.byte_position, res.method_class, res.version_major,
					res.version_minor}));
			res.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offer one word, holding it until the parser takes it
	task automatic put_word(input logic k, input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.data_byte <= b;
		do @(posedge clk); while (req.ready !== 1'b1);
		void'(board.note_word(k, b));
		live_count++;
	endtask

	task automatic put_bytes(ref logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i]) put_word(1'b0, seq[i]);
	endtask

	function automatic void push_text(ref logic [BYTE_W-1:0] seq[$], input string s);
		for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte_not(input logic [BYTE_W-1:0] x0,
			input logic [BYTE_W-1:0] x1, input logic [BYTE_W-1:0] x2,
			input logic [BYTE_W-1:0] x3);
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255));
		while (b == x0 || b == x1 || b == x2 || b == x3);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_method_char();
		int unsigned n;
		n = $urandom_range(0, 26);
		return (n == 26) ? CH_UNDER : CH_UPA + BYTE_W'(n);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_blank();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	// Build one request head: mostly well formed, some damaged, some noise
	function automatic void build_request(ref logic [BYTE_W-1:0] seq[$]);
		int unsigned n;
		seq.delete();
		if ($urandom_range(0, 99) < 5) begin
			repeat ($urandom_range(1, 24)) seq.push_back(BYTE_W'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 2)) seq.push_back(pick_blank());

		// method
		case ($urandom_range(0, 4))
			0: push_text(seq, "GET");
			1: push_text(seq, "POST");
			2: push_text(seq, "HEAD");
			3: begin
				n = $urandom_range(0, 2);
				seq.push_back(n == 0 ? CH_G : n == 1 ? CH_P : CH_H);
				repeat ($urandom_range(1, 4)) seq.push_back(pick_method_char());
			end
			default: begin
				seq.push_back(pick_method_char());
				repeat ($urandom_range(0, 8))
					seq.push_back($urandom_range(0, 9) == 0 ? pick_blank()
						: pick_method_char());
			end
		endcase
		repeat ($urandom_range(1, 3)) seq.push_back(CH_SP);

		// uri and version
		seq.push_back(CH_SLASH);
		repeat ($urandom_range(0, 8)) seq.push_back(pick_byte_not(CH_SP, CH_SP, CH_SP, CH_SP));
		repeat ($urandom_range(1, 2)) seq.push_back(CH_SP);
		push_text(seq, "HTTP/1.");
		seq.push_back(CH_DIG0 + BYTE_W'($urandom_range(0, 9)));
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 3)) seq.push_back(pick_byte_not(CH_CR, CH_CR, CH_CR, CH_CR));
		seq.push_back(CH_CR);
		seq.push_back(CH_LF);
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 2)) seq.push_back(pick_blank());

		// header lines
		repeat ($urandom_range(0, 4)) begin
			seq.push_back(pick_byte_not(CH_CR, CH_LF, CH_SP, CH_COLON));
			repeat ($urandom_range(0, 5)) seq.push_back(pick_byte_not(CH_SP, CH_COLON, CH_SP, CH_SP));
			if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) seq.push_back(CH_SP);
			seq.push_back(CH_COLON);
			repeat ($urandom_range(0, 2)) seq.push_back(CH_SP);
			seq.push_back(pick_byte_not(CH_SP, CH_CR, CH_LF, CH_SP));
			repeat ($urandom_range(0, 8)) seq.push_back(pick_byte_not(CH_CR, CH_LF, CH_CR, CH_LF));
			if ($urandom_range(0, 99) < 80) seq.push_back(CH_CR);
			seq.push_back(CH_LF);
		end
		seq.push_back(CH_CR);
		seq.push_back(CH_LF);
		if ($urandom_range(0, 99) < 10)
			repeat ($urandom_range(1, 3)) seq.push_back(BYTE_W'($urandom_range(0, 255)));

		// damage: overwrite one byte, or cut the head short
		if ($urandom_range(0, 99) < 20)
			seq[$urandom_range(0, seq.size() - 1)] = BYTE_W'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 8) begin
			n = $urandom_range(1, seq.size());
			while (seq.size() > n) void'(seq.pop_back());
		end
	endfunction

	task automatic run_phase(input int unsigned gap, input int unsigned stall,
			input int unsigned target);
		logic [BYTE_W-1:0] seq[$];
		send_gap_pct = gap;
		stall_pct = stall;
		live_count = 0;
		while (live_count < target) begin
			build_request(seq);
			put_word(1'b1, BYTE_W'($urandom_range(0, 255)));
			put_bytes(seq);
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] seq[$];

		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= 1'b0;
		req.data_byte <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short GET, key with space before colon, bare LF, bad method
		put_word(1'b1, 8'h00);
		push_text(seq, "GET / HTTP/1.9");
		seq.push_back(CH_CR);
		seq.push_back(CH_LF);
		push_text(seq, "k :v");
		seq.push_back(CH_LF);
		seq.push_back(CH_CR);
		seq.push_back(CH_LF);
		put_bytes(seq);
		put_word(1'b1, 8'hFF);
		put_word(1'b0, 8'hFF);
		put_word(1'b0, 8'h00);

		run_phase(28, 76, 350);
		run_phase(76, 28, 350);
		run_phase(0, 0, 350);
		req.valid <= 1'b0;

		// drain, then allow stray words to show up
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
